>>> design/mkr_pkg.sv
// package: shared types and constants for the kinetic rate block
package mkr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        KIND_FIRST  = 2'd0,
        KIND_INHIB  = 2'd1,
        KIND_MONOD  = 2'd2,
        KIND_LINEAR = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MU_MAX  = 3'd0,
        REG_ACTIVE  = 3'd1,
        REG_KINDS   = 3'd2,
        REG_MASK    = 3'd3,
        REG_CONST_0 = 3'd4,
        REG_CONST_1 = 3'd5,
        REG_CONST_2 = 3'd6,
        REG_CONST_3 = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0] factor;
        logic              sat;
        logic              used;
    } lane_res_t;

endpackage

>>> design/mkr_lane.sv
// module: one term lane, pipelined restoring divider, linear product or unit factor
module mkr_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      adv,
    input  logic [mkr_pkg::WORD_W-1:0] k_in,
    input  logic [mkr_pkg::WORD_W-1:0] c_in,
    input  mkr_pkg::kind_t            kind_in,
    input  logic                      used_in,
    output mkr_pkg::lane_res_t        res
);
    import mkr_pkg::*;

    localparam int NUM_W = WORD_W + FRAC_BITS;
    localparam int DEN_W = WORD_W + 1;
    localparam int REM_W = DEN_W + 1;
    localparam int LAT = NUM_W;

    logic [NUM_W-1:0] quo_reg [0:LAT];
    logic [REM_W-1:0] rem_reg [0:LAT];
    logic [DEN_W-1:0] den_reg [0:LAT];
    kind_t            kind_reg [0:LAT];
    logic             used_reg [0:LAT];
    logic [2*WORD_W-1:0] lin_reg [0:LAT];

    logic [DEN_W-1:0] den_in;
    logic [WORD_W-1:0] numer;
    assign den_in = {1'b0, k_in} + {1'b0, c_in};
    assign numer = (kind_in == KIND_INHIB) ? k_in : c_in;

    always_ff @(posedge aclk) begin
        if (adv) begin
            quo_reg[0]  <= {numer, {FRAC_BITS{1'b0}}};
            rem_reg[0]  <= '0;
            den_reg[0]  <= den_in;
            kind_reg[0] <= kind_in;
            used_reg[0] <= used_in;
            lin_reg[0]  <= {{WORD_W{1'b0}}, k_in} * {{WORD_W{1'b0}}, c_in};
        end
    end

    for (genvar s = 0; s < LAT; s++) begin : g_div
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] diff;
        assign sh = {rem_reg[s][REM_W-2:0], quo_reg[s][NUM_W-1]};
        assign diff = sh - {1'b0, den_reg[s]};
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (!diff[REM_W-1]) begin
                    rem_reg[s+1] <= diff;
                    quo_reg[s+1] <= {quo_reg[s][NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg[s+1] <= sh;
                    quo_reg[s+1] <= {quo_reg[s][NUM_W-2:0], 1'b0};
                end
                den_reg[s+1]  <= den_reg[s];
                kind_reg[s+1] <= kind_reg[s];
                used_reg[s+1] <= used_reg[s];
                lin_reg[s+1]  <= lin_reg[s];
            end
        end
    end

    logic [2*WORD_W-1:0] lin_sh;
    logic [NUM_W-1:0] q;
    assign lin_sh = lin_reg[LAT] >> FRAC_BITS;
    assign q = quo_reg[LAT];

    always_comb begin
        res.used = used_reg[LAT];
        res.sat = 1'b0;
        res.factor = '0;
        case (kind_reg[LAT])
            KIND_FIRST: res.factor = WORD_W'(64'd1 << FRAC_BITS);
            KIND_INHIB, KIND_MONOD: begin
                if (den_reg[LAT] == '0) res.factor = '0;
                else if (q[NUM_W-1:WORD_W] != '0) res.factor = '1;
                else res.factor = q[WORD_W-1:0];
            end
            KIND_LINEAR: begin
                if (lin_sh[2*WORD_W-1:WORD_W] != '0) begin
                    res.factor = '1;
                    res.sat = 1'b1;
                end else begin
                    res.factor = lin_sh[WORD_W-1:0];
                end
            end
            default: res.factor = '0;
        endcase
    end

endmodule

>>> design/mkr_merge.sv
// module: merging chain that multiplies the lane factors into the rate
module mkr_merge #(
    parameter int MAX_TERMS = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      adv,
    input  logic [mkr_pkg::WORD_W-1:0] mu_in,
    input  mkr_pkg::lane_res_t        lanes [MAX_TERMS],
    output logic [mkr_pkg::WORD_W-1:0] rate,
    output logic                      sat
);
    import mkr_pkg::*;

    logic [WORD_W-1:0] acc_reg [0:MAX_TERMS];
    logic              sat_reg [0:MAX_TERMS];
    lane_res_t         hold_reg [MAX_TERMS][MAX_TERMS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            acc_reg[0] <= mu_in;
            sat_reg[0] <= 1'b0;
            for (int i = 0; i < MAX_TERMS; i++) hold_reg[0][i] <= lanes[i];
        end
    end

    for (genvar s = 0; s < MAX_TERMS; s++) begin : g_step
        logic [2*WORD_W-1:0] prod;
        logic [2*WORD_W-1:0] psh;
        assign prod = {{WORD_W{1'b0}}, acc_reg[s]} *
                      {{WORD_W{1'b0}}, hold_reg[s][s].factor};
        assign psh = prod >> FRAC_BITS;
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (!hold_reg[s][s].used) begin
                    acc_reg[s+1] <= acc_reg[s];
                    sat_reg[s+1] <= sat_reg[s];
                end else if (psh[2*WORD_W-1:WORD_W] != '0) begin
                    acc_reg[s+1] <= '1;
                    sat_reg[s+1] <= 1'b1;
                end else begin
                    acc_reg[s+1] <= psh[WORD_W-1:0];
                    sat_reg[s+1] <= sat_reg[s] | hold_reg[s][s].sat;
                end
            end
        end
        if (s + 1 < MAX_TERMS) begin : g_hold
            always_ff @(posedge aclk) begin
                if (adv) begin
                    for (int i = 0; i < MAX_TERMS; i++)
                        hold_reg[s+1][i] <= hold_reg[s][i];
                end
            end
        end
    end

    assign rate = acc_reg[MAX_TERMS];
    assign sat = sat_reg[MAX_TERMS];

endmodule

>>> design/monod_kinetic_rate.sv
// top level: streaming kinetic rate block with config registers
// Each beat carries four concentrations and gives one rate beat. A new beat is taken every
// cycle while the pipeline advances. The path runs through the one-bit-per-stage divider
// pipeline in each term lane, followed by one multiply stage per term in the merge chain
// and the output register. The whole pipeline moves only while the output register is
// empty or being drained.
module monod_kinetic_rate #(
    parameter int MAX_TERMS = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // conc_0, conc_1, conc_2, conc_3
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // rate
    output logic         m_tuser    // saturated
);
    import mkr_pkg::*;

    localparam int LAT = WORD_W + FRAC_BITS + 2 + MAX_TERMS + 1;

    logic [WORD_W-1:0] mu_reg;
    logic [2:0]        act_reg;
    logic [7:0]        kinds_reg;
    logic [3:0]        mask_reg;
    logic [WORD_W-1:0] k_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_reg <= '0; act_reg <= '0; kinds_reg <= '0; mask_reg <= '0;
            for (int i = 0; i < 4; i++) k_reg[i] <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_MU_MAX:  mu_reg <= cfg_data;
                REG_ACTIVE:  act_reg <= cfg_data[2:0];
                REG_KINDS:   kinds_reg <= cfg_data[7:0];
                REG_MASK:    mask_reg <= cfg_data[3:0];
                REG_CONST_0: k_reg[0] <= cfg_data;
                REG_CONST_1: k_reg[1] <= cfg_data;
                REG_CONST_2: k_reg[2] <= cfg_data;
                REG_CONST_3: k_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    logic [LAT-1:0] vld_reg;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // mu travels alongside the lane pipeline
    logic [WORD_W-1:0] mu_pipe_reg [0:WORD_W+FRAC_BITS];
    always_ff @(posedge aclk) begin
        if (adv) begin
            mu_pipe_reg[0] <= mu_reg;
            for (int i = 1; i <= WORD_W + FRAC_BITS; i++)
                mu_pipe_reg[i] <= mu_pipe_reg[i-1];
        end
    end

    lane_res_t lanes [MAX_TERMS];
    logic [2:0] n_eff;
    assign n_eff = (act_reg > 3'(MAX_TERMS)) ? 3'(MAX_TERMS) : act_reg;

    for (genvar i = 0; i < MAX_TERMS; i++) begin : g_lane
        logic [WORD_W-1:0] c;
        assign c = mask_reg[i] ? s_tdata[i*WORD_W +: WORD_W] : '0;
        mkr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk(aclk), .adv(adv),
            .k_in(k_reg[i]), .c_in(c),
            .kind_in(kind_t'(kinds_reg[2*i +: 2])),
            .used_in(3'(i) < n_eff),
            .res(lanes[i])
        );
    end

    logic [WORD_W-1:0] rate;
    logic sat;
    mkr_merge #(.MAX_TERMS(MAX_TERMS), .FRAC_BITS(FRAC_BITS)) u_merge (
        .aclk(aclk), .adv(adv), .mu_in(mu_pipe_reg[WORD_W+FRAC_BITS]),
        .lanes(lanes), .rate(rate), .sat(sat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata <= rate;
            m_tuser <= sat;
        end
    end
    assign m_tvalid = vld_reg[LAT-1];

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready not tied to output drain");

endmodule
